// File: src/scma_pkg.sv
package scma_pkg;

	localparam int CHUNK_FRAMES = 2048;
	localparam int SUM_W = 32;

	localparam int FRAME_W = 11;
	localparam int SAMPLE_W = 16;
	localparam int VOL_W = 8;
	localparam int VOL_SHIFT = 8;
	localparam int PROD_W = SAMPLE_W + VOL_W + 1;

	localparam int FRAME_AW = $clog2(CHUNK_FRAMES);
	localparam int RANGE_W = (FRAME_W > $clog2(CHUNK_FRAMES + 1)) ?
		FRAME_W : $clog2(CHUNK_FRAMES + 1);
	localparam int ADDR_EXT_W = (FRAME_W > FRAME_AW) ? FRAME_W : FRAME_AW;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] REQ_MIX = 2'd0;
	localparam logic [1:0] REQ_RAW = 2'd1;
	localparam logic [1:0] REQ_READ = 2'd2;

	localparam logic [7:0] BYTE_BIAS = 8'h80;
	localparam logic signed [SAMPLE_W-1:0] PCM_MAX = 16'sh7fff;
	localparam logic signed [SAMPLE_W-1:0] PCM_MIN = -16'sh8000;

	typedef struct packed {
		logic [1:0] req_type;
		logic [FRAME_W-1:0] frame_index;
		logic signed [SAMPLE_W-1:0] sample_value;
		logic sample_is_8bit;
		logic [VOL_W-1:0] left_volume;
		logic [VOL_W-1:0] right_volume;
		logic signed [SAMPLE_W-1:0] raw_left;
		logic signed [SAMPLE_W-1:0] raw_right;
	} item_t;

	typedef struct packed {
		logic [FRAME_W-1:0] out_frame;
		logic signed [SAMPLE_W-1:0] pcm_left;
		logic signed [SAMPLE_W-1:0] pcm_right;
	} result_t;

	typedef enum logic {
		OP_ADD,
		OP_READ
	} op_t;

	typedef struct packed {
		op_t op;
		logic in_range;
		logic [FRAME_W-1:0] frame;
		logic signed [SAMPLE_W-1:0] delta_left;
		logic signed [SAMPLE_W-1:0] delta_right;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MODIFY
	} back_state_t;

	function automatic logic frame_in_range(input logic [FRAME_W-1:0] frame);
		return RANGE_W'(frame) < RANGE_W'(CHUNK_FRAMES);
	endfunction

endpackage

// File: src/scma_front.sv
module scma_front import scma_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input item_t item,
	input logic clear_busy,
	input logic q_full,
	output logic q_push,
	output cmd_t q_cmd
);

	logic s1_valid_s1;
	op_t op_s1;
	logic in_range_s1;
	logic [FRAME_W-1:0] frame_s1;
	logic signed [PROD_W-1:0] prod_l_s1;
	logic signed [PROD_W-1:0] prod_r_s1;

	logic accept;
	logic useful;
	logic in_range;
	logic signed [SAMPLE_W-1:0] data;
	logic signed [PROD_W-1:0] prod_l;
	logic signed [PROD_W-1:0] prod_r;

	assign item_stall = clear_busy || (s1_valid_s1 && q_full);
	assign accept = item_valid && !item_stall;
	assign in_range = frame_in_range(item.frame_index);

	always_comb begin
		useful = 1'b0;
		case (item.req_type)
			REQ_MIX, REQ_RAW: useful = in_range;
			REQ_READ: useful = 1'b1;
			default: useful = 1'b0;
		endcase
	end

	// 8-bit samples: (byte - 128) << 8
	assign data = item.sample_is_8bit ?
		{item.sample_value[7:0] ^ BYTE_BIAS, 8'h00} : item.sample_value;

	always_comb begin
		if (item.req_type == REQ_RAW) begin
			prod_l = {item.raw_left[SAMPLE_W-1], item.raw_left, {VOL_SHIFT{1'b0}}};
			prod_r = {item.raw_right[SAMPLE_W-1], item.raw_right, {VOL_SHIFT{1'b0}}};
		end else begin
			prod_l = data * $signed({1'b0, item.left_volume});
			prod_r = data * $signed({1'b0, item.right_volume});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (accept) begin
			s1_valid_s1 <= useful;
		end else if (q_push) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= (item.req_type == REQ_READ) ? OP_READ : OP_ADD;
			in_range_s1 <= in_range;
			frame_s1 <= item.frame_index;
			prod_l_s1 <= prod_l;
			prod_r_s1 <= prod_r;
		end
	end

	assign q_push = s1_valid_s1 && !q_full;

	// floor of product / 256 is the arithmetic shift
	always_comb begin
		q_cmd.op = op_s1;
		q_cmd.in_range = in_range_s1;
		q_cmd.frame = frame_s1;
		q_cmd.delta_left = prod_l_s1[SAMPLE_W+VOL_SHIFT-1:VOL_SHIFT];
		q_cmd.delta_right = prod_r_s1[SAMPLE_W+VOL_SHIFT-1:VOL_SHIFT];
	end

endmodule

// File: src/scma_queue.sv
module scma_queue import scma_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input cmd_t push_cmd,
	output logic full,
	input logic pop,
	output logic not_empty,
	output cmd_t head
);

	cmd_t slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full = count_q == QCNT_W'(QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign head = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// File: src/scma_back.sv
module scma_back import scma_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input cmd_t cmd,
	output logic cmd_pop,
	output logic clear_busy,
	output logic result_valid,
	input logic result_stall,
	output result_t result
);

	logic [2*SUM_W-1:0] sums_mem [CHUNK_FRAMES];

	back_state_t state_q;
	back_state_t state_d;
	logic [FRAME_AW-1:0] clr_q;
	cmd_t cur_q;
	logic [FRAME_AW-1:0] addr_q;
	logic [2*SUM_W-1:0] rd_q;
	logic result_valid_q;
	result_t result_q;

	logic [ADDR_EXT_W-1:0] frame_ext;
	logic [FRAME_AW-1:0] cmd_addr;
	logic mem_re;
	logic mem_we;
	logic [FRAME_AW-1:0] mem_waddr;
	logic [2*SUM_W-1:0] mem_wdata;
	logic produce;
	logic signed [SUM_W-1:0] old_l;
	logic signed [SUM_W-1:0] old_r;
	logic signed [SUM_W-1:0] new_l;
	logic signed [SUM_W-1:0] new_r;
	result_t result_d;

	assign frame_ext = ADDR_EXT_W'(cmd.frame);
	assign cmd_addr = frame_ext[FRAME_AW-1:0];

	assign old_l = rd_q[2*SUM_W-1:SUM_W];
	assign old_r = rd_q[SUM_W-1:0];
	assign new_l = old_l + {{(SUM_W-SAMPLE_W){cur_q.delta_left[SAMPLE_W-1]}},
		cur_q.delta_left};
	assign new_r = old_r + {{(SUM_W-SAMPLE_W){cur_q.delta_right[SAMPLE_W-1]}},
		cur_q.delta_right};

	function automatic logic signed [SAMPLE_W-1:0] clamp(input logic signed [SUM_W-1:0] v);
		if (v > SUM_W'(PCM_MAX)) begin
			return PCM_MAX;
		end else if (v < SUM_W'(PCM_MIN)) begin
			return PCM_MIN;
		end
		return v[SAMPLE_W-1:0];
	endfunction

	always_comb begin
		state_d = state_q;
		cmd_pop = 1'b0;
		mem_re = 1'b0;
		mem_we = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = '0;
		produce = 1'b0;
		result_d.out_frame = cur_q.frame;
		result_d.pcm_left = '0;
		result_d.pcm_right = '0;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_waddr = clr_q;
				if (clr_q == FRAME_AW'(CHUNK_FRAMES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					mem_re = cmd.in_range;
					state_d = ST_MODIFY;
				end
			end
			ST_MODIFY: begin
				if (cur_q.op == OP_READ) begin
					if (!(result_valid_q && result_stall)) begin
						produce = 1'b1;
						mem_we = cur_q.in_range;
						if (cur_q.in_range) begin
							result_d.pcm_left = clamp(old_l);
							result_d.pcm_right = clamp(old_r);
						end
						state_d = ST_IDLE;
					end
				end else begin
					mem_we = 1'b1;
					mem_wdata = {new_l, new_r};
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (produce) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cur_q <= cmd;
			addr_q <= cmd_addr;
		end
		if (produce) begin
			result_q <= result_d;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			sums_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= sums_mem[cmd_addr];
		end
	end

	assign clear_busy = state_q == ST_CLEAR;
	assign result_valid = result_valid_q;
	assign result = result_q;

endmodule

// File: src/stereo_chunk_mix_accumulator.sv
// a read request passes the front register, the queue, the sum memory read and the result register
// the back end reads then writes the sum memory for each request before it takes the next one
// the front register and a four-entry queue absorb short bursts at one request a cycle while item_stall is low
// reset: once arst_n is released the sum memory is swept to zero, one frame a cycle, over
// all 2048 frames, with item_stall held high until the sweep ends
module stereo_chunk_mix_accumulator import scma_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input item_t item,
	output logic result_valid,
	input logic result_stall,
	output result_t result
);

	logic clear_busy;
	logic q_full;
	logic q_push;
	cmd_t q_cmd;
	logic q_pop;
	logic q_not_empty;
	cmd_t q_head;

	scma_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.clear_busy(clear_busy),
		.q_full(q_full),
		.q_push(q_push),
		.q_cmd(q_cmd)
	);

	scma_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_cmd(q_cmd),
		.full(q_full),
		.pop(q_pop),
		.not_empty(q_not_empty),
		.head(q_head)
	);

	scma_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(q_not_empty),
		.cmd(q_head),
		.cmd_pop(q_pop),
		.clear_busy(clear_busy),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

endmodule

// File: src/scma_checker.sv
module scma_checker import scma_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input logic item_stall,
	input item_t item,
	input logic result_valid,
	input logic result_stall,
	input result_t result
);

	logic [3:0] reads_q;
	logic read_in;
	logic read_out;

	assign read_in = item_valid && !item_stall && (item.req_type == REQ_READ);
	assign read_out = result_valid && !result_stall;

	// reads whose result has not yet made its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reads_q <= '0;
		end else if (read_in && !read_out) begin
			reads_q <= reads_q + 1'b1;
		end else if (read_out && !read_in) begin
			reads_q <= reads_q - 1'b1;
		end
	end

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result))
		else $error("result changed while stalled");

	a_result_has_read: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> reads_q != '0)
		else $error("result without an outstanding read");

	a_out_of_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !frame_in_range(result.out_frame) |->
			result.pcm_left == '0 && result.pcm_right == '0)
		else $error("out of range frame read not zero");

endmodule

bind stereo_chunk_mix_accumulator scma_checker u_scma_checker (.*);

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import scma_pkg::*;

	localparam logic [1:0] REQ_SPARE = 2'd3;
	localparam int QUIET_LIMIT = 8192;
	localparam int HOLD_CYCLES = 200;
	localparam int SAT_ADDS = 40;
	localparam int SAT_FRAME = 1000;
	localparam int PHASE_ITEMS = 280;
	localparam int PRINT_CAP = 100;

	typedef struct packed {
		item_t it;
		logic typed;
		result_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;

	logic [SUM_W-1:0] left_acc [CHUNK_FRAMES];
	logic [SUM_W-1:0] right_acc [CHUNK_FRAMES];
	result_t owed_reads [$];
	dir_row_t dir_rows [$];
	result_t want_now;
	int errors = 0;
	int quiet_cycles = 0;
	int send_idle = 0;
	int recv_idle = 0;
	logic long_hold = 1'b0;
	logic hold_done = 1'b0;
	int hold_cnt = 0;

	stereo_chunk_mix_accumulator uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always #1 clk = ~clk;

	task automatic report_mismatch(input string what, input int got, input int want);
		if (errors < PRINT_CAP)
			$display("mismatch %s: got %0d, want %0d", what, got, want);
		errors++;
	endtask

	function automatic logic signed [SAMPLE_W-1:0] sat16(input logic [SUM_W-1:0] acc);
		longint v;
		v = longint'($signed(acc));
		if (v > longint'(PCM_MAX))
			return PCM_MAX;
		if (v < longint'(PCM_MIN))
			return PCM_MIN;
		return SAMPLE_W'(v);
	endfunction

	// updates the sum store and tells whether the request yields a frame
	function automatic logic mix_predict(input item_t it, output result_t res);
		longint sample;
		longint lpart;
		longint rpart;
		int f;
		f = int'(it.frame_index);
		res = '0;
		if (it.req_type == REQ_READ) begin
			res.out_frame = it.frame_index;
			if (f < CHUNK_FRAMES) begin
				res.pcm_left = sat16(left_acc[f]);
				res.pcm_right = sat16(right_acc[f]);
				left_acc[f] = '0;
				right_acc[f] = '0;
			end
			return 1'b1;
		end
		if (f >= CHUNK_FRAMES)
			return 1'b0;
		if (it.req_type == REQ_MIX) begin
			if (it.sample_is_8bit)
				sample = (longint'(it.sample_value[7:0]) - longint'(BYTE_BIAS)) * 256;
			else
				sample = longint'($signed(it.sample_value));
			lpart = (sample * longint'(it.left_volume)) >>> VOL_SHIFT;
			rpart = (sample * longint'(it.right_volume)) >>> VOL_SHIFT;
			left_acc[f] = left_acc[f] + SUM_W'(lpart);
			right_acc[f] = right_acc[f] + SUM_W'(rpart);
		end else if (it.req_type == REQ_RAW) begin
			lpart = longint'($signed(it.raw_left));
			rpart = longint'($signed(it.raw_right));
			left_acc[f] = left_acc[f] + SUM_W'(lpart);
			right_acc[f] = right_acc[f] + SUM_W'(rpart);
		end
		return 1'b0;
	endfunction

	task automatic add_row(input logic [1:0] op, input int f, input int s, input bit b8,
			input int lv, input int rv, input int rl, input int rr, input bit typed,
			input int wl = 0, input int wr = 0);
		dir_row_t r;
		r.it.req_type = op;
		r.it.frame_index = FRAME_W'(f);
		r.it.sample_value = SAMPLE_W'(s);
		r.it.sample_is_8bit = b8;
		r.it.left_volume = VOL_W'(lv);
		r.it.right_volume = VOL_W'(rv);
		r.it.raw_left = SAMPLE_W'(rl);
		r.it.raw_right = SAMPLE_W'(rr);
		r.typed = typed;
		r.want.out_frame = FRAME_W'(f);
		r.want.pcm_left = SAMPLE_W'(wl);
		r.want.pcm_right = SAMPLE_W'(wr);
		dir_rows.push_back(r);
	endtask

	function automatic item_t random_request();
		item_t it;
		logic [95:0] bits;
		int pick;
		int hot;
		bits = {$urandom, $urandom, $urandom};
		it = bits[$bits(item_t)-1:0];
		pick = $urandom_range(99);
		if (pick < 40)
			it.req_type = REQ_MIX;
		else if (pick < 70)
			it.req_type = REQ_RAW;
		else if (pick < 95)
			it.req_type = REQ_READ;
		else
			it.req_type = REQ_SPARE;
		// mostly a few busy frames so that sums build up and saturate
		hot = $urandom_range(7);
		if ($urandom_range(99) < 75)
			it.frame_index = FRAME_W'(hot < 4 ? hot : CHUNK_FRAMES - 8 + hot);
		else
			it.frame_index = FRAME_W'($urandom_range(CHUNK_FRAMES - 1));
		return it;
	endfunction

	// called at a rising edge, returns at the edge of the transfer
	task automatic offer(input item_t it, input bit typed, input result_t want);
		result_t predicted;
		while (send_idle != 0 && $urandom_range(99) < send_idle) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		if (mix_predict(it, predicted))
			owed_reads.push_back(typed ? want : predicted);
	endtask

	task automatic settle();
		item_valid <= 1'b0;
		do
			@(posedge clk);
		while (owed_reads.size() != 0);
	endtask

	always @(posedge clk) begin
		if (long_hold && !hold_done) begin
			result_stall <= 1'b1;
			hold_cnt <= hold_cnt + 1;
			if (hold_cnt == HOLD_CYCLES - 1)
				hold_done <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < recv_idle);
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (owed_reads.size() == 0) begin
				report_mismatch("result with nothing owed, frame", int'(result.out_frame), -1);
			end else begin
				want_now = owed_reads.pop_front();
				if (result.out_frame !== want_now.out_frame)
					report_mismatch("out_frame", int'(result.out_frame),
						int'(want_now.out_frame));
				if (result.pcm_left !== want_now.pcm_left)
					report_mismatch("pcm_left", int'(result.pcm_left),
						int'(want_now.pcm_left));
				if (result.pcm_right !== want_now.pcm_right)
					report_mismatch("pcm_right", int'(result.pcm_right),
						int'(want_now.pcm_right));
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		item_t sat_add;
		result_t sat_want;
		foreach (left_acc[i]) begin
			left_acc[i] = '0;
			right_acc[i] = '0;
		end

		add_row(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0);
		add_row(REQ_READ, 2047, 'hffff, 1, 255, 255, -1, -1, 1, 0, 0);
		add_row(REQ_RAW, 5, 'h1234, 1, 255, 255, 32767, -32768, 0);
		add_row(REQ_RAW, 5, 'h1234, 0, 255, 255, 32767, -32768, 0);
		add_row(REQ_READ, 5, 0, 0, 0, 0, 0, 0, 1, 32767, -32768);
		add_row(REQ_READ, 5, 0, 0, 0, 0, 0, 0, 1, 0, 0);
		add_row(REQ_MIX, 7, 32767, 0, 255, 0, 1, 1, 0);
		add_row(REQ_MIX, 7, -32768, 0, 255, 255, -32768, 32767, 0);
		add_row(REQ_MIX, 7, 'hff00, 1, 128, 1, 0, 0, 0);
		add_row(REQ_MIX, 7, 'h00ff, 1, 255, 255, 0, 0, 0);
		add_row(REQ_READ, 7, 0, 0, 0, 0, 0, 0, 0);
		add_row(REQ_SPARE, 9, 32767, 0, 255, 255, 32767, 32767, 0);
		add_row(REQ_READ, 9, 0, 0, 0, 0, 0, 0, 1, 0, 0);
		add_row(REQ_MIX, 10, -32768, 0, 0, 0, 0, 0, 0);
		add_row(REQ_READ, 10, 0, 0, 0, 0, 0, 0, 1, 0, 0);
		add_row(REQ_MIX, 2047, -1, 0, 1, 255, 0, 0, 0);
		add_row(REQ_READ, 2047, 0, 0, 0, 0, 0, 0, 1, -1, -1);
		add_row(REQ_RAW, 3, 0, 0, 0, 0, -1, 1, 0);
		add_row(REQ_MIX, 3, 'h7f80, 1, 255, 255, 0, 0, 0);
		add_row(REQ_READ, 3, 0, 0, 0, 0, 0, 0, 1, -1, 1);
		add_row(REQ_RAW, 4, 0, 0, 0, 0, 100, -100, 0);
		add_row(REQ_RAW, 4, 0, 0, 0, 0, 200, -200, 0);
		add_row(REQ_READ, 4, 0, 0, 0, 0, 0, 0, 1, 300, -300);
		add_row(REQ_READ, 4, 0, 0, 0, 0, 0, 0, 1, 0, 0);

		send_idle = 23;
		recv_idle = 64;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			offer(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
		settle();

		// pile one frame far past the pcm range so both sides clamp
		sat_add = '0;
		sat_add.req_type = REQ_RAW;
		sat_add.frame_index = FRAME_W'(SAT_FRAME);
		sat_add.raw_left = PCM_MAX;
		sat_add.raw_right = PCM_MIN;
		repeat (SAT_ADDS)
			offer(sat_add, 1'b0, '0);
		sat_add.req_type = REQ_READ;
		sat_want.out_frame = FRAME_W'(SAT_FRAME);
		sat_want.pcm_left = PCM_MAX;
		sat_want.pcm_right = PCM_MIN;
		offer(sat_add, 1'b1, sat_want);
		settle();

		send_idle = 23;
		recv_idle <= 64;
		repeat (PHASE_ITEMS)
			offer(random_request(), 1'b0, '0);
		settle();

		send_idle = 64;
		recv_idle <= 23;
		repeat (PHASE_ITEMS)
			offer(random_request(), 1'b0, '0);
		settle();

		send_idle = 0;
		recv_idle <= 0;
		long_hold <= 1'b1;
		repeat (PHASE_ITEMS)
			offer(random_request(), 1'b0, '0);
		settle();

		repeat (16) @(posedge clk);
		if (owed_reads.size() != 0)
			report_mismatch("reads never answered", owed_reads.size(), 0);
		if (errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
